// ===== rtl/saq_pkg.sv =====
`default_nettype none
package saq_pkg;

  // Unit-vector component width and internal datapath widths
  localparam int UNIT_W   = 32;
  localparam int NORM_W   = 31;
  localparam int RAD_W    = 64;
  localparam int ROOT_W   = 32;
  localparam int SQRT_LAT = ROOT_W;
  localparam int DIV_LAT  = ROOT_W;

  typedef enum logic [1:0] {
    PATH_IDENT   = 2'd0,
    PATH_ALT     = 2'd1,
    PATH_GEN     = 2'd2,
    PATH_GENERAL = 2'd3
  } path_t;

  typedef struct packed {
    logic signed [31:0] src_x;
    logic signed [31:0] src_y;
    logic signed [31:0] src_z;
    logic signed [31:0] dst_x;
    logic signed [31:0] dst_y;
    logic signed [31:0] dst_z;
    logic signed [31:0] alt_axis_x;
    logic signed [31:0] alt_axis_y;
    logic signed [31:0] alt_axis_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic [1:0]         path_taken;
  } out_item_t;

endpackage
`default_nettype wire

// ===== rtl/saq_delay.sv =====
`default_nettype none
module saq_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] tap_r [0:DEPTH-1];

  // advance the shift line one tap per cycle
  always_ff @(posedge clk) begin
    tap_r[0] <= din;
    for (int i = 1; i < DEPTH; i++) begin
      tap_r[i] <= tap_r[i-1];
    end
  end

  assign dout = tap_r[DEPTH-1];

endmodule
`default_nettype wire

// ===== rtl/saq_isqrt.sv =====
`default_nettype none
module saq_isqrt (
  input  logic                        clk,
  input  logic [saq_pkg::RAD_W-1:0]   rad,
  output logic [saq_pkg::ROOT_W-1:0]  root
);

  localparam int RW    = saq_pkg::RAD_W;
  localparam int QW    = saq_pkg::ROOT_W;
  localparam int REM_W = QW + 3;
  localparam int LAT   = saq_pkg::SQRT_LAT;

  logic [RW-1:0]    rad_r  [0:LAT-1];
  logic [REM_W-1:0] rem_r  [0:LAT-1];
  logic [QW-1:0]    root_r [0:LAT-1];
  logic [RW-1:0]    rad_in  [0:LAT-1];
  logic [REM_W-1:0] rem_in  [0:LAT-1];
  logic [QW-1:0]    root_in [0:LAT-1];

  // one root bit per stage, two radicand bits consumed each step
  for (genvar k = 0; k < LAT; k++) begin : g_step
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign rad_in[k]  = rad;
      assign rem_in[k]  = '0;
      assign root_in[k] = '0;
    end else begin : g_next
      assign rad_in[k]  = rad_r[k-1];
      assign rem_in[k]  = rem_r[k-1];
      assign root_in[k] = root_r[k-1];
    end

    always_comb begin
      rem_sh = {rem_in[k][REM_W-3:0], rad_in[k][RW-1 -: 2]};
      trial  = {1'b0, root_in[k], 2'b01};
      ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      rad_r[k]  <= {rad_in[k][RW-3:0], 2'b00};
      rem_r[k]  <= ge ? (rem_sh - trial) : rem_sh;
      root_r[k] <= {root_in[k][QW-2:0], ge};
    end
  end

  assign root = root_r[LAT-1];

endmodule
`default_nettype wire

// ===== rtl/saq_div.sv =====
`default_nettype none
module saq_div (
  input  logic                          clk,
  input  logic [2*saq_pkg::ROOT_W-1:0]  dividend,
  input  logic [saq_pkg::ROOT_W-1:0]    divisor,
  output logic [saq_pkg::ROOT_W-1:0]    quotient
);

  localparam int QW  = saq_pkg::ROOT_W;
  localparam int LAT = saq_pkg::DIV_LAT;

  logic [QW-1:0] rem_r [0:LAT-1];
  logic [QW-1:0] lq_r  [0:LAT-1];
  logic [QW-1:0] dvs_r [0:LAT-1];
  logic [QW-1:0] rem_in [0:LAT-1];
  logic [QW-1:0] lq_in  [0:LAT-1];
  logic [QW-1:0] dvs_in [0:LAT-1];

  // restoring division, one quotient bit per stage; the upper half of the
  // dividend is below the divisor, so the quotient fits QW bits
  for (genvar k = 0; k < LAT; k++) begin : g_step
    logic [QW:0] rem_sh;
    logic [QW:0] diff;
    logic        ge;

    if (k == 0) begin : g_first
      assign rem_in[k] = dividend[2*QW-1:QW];
      assign lq_in[k]  = dividend[QW-1:0];
      assign dvs_in[k] = divisor;
    end else begin : g_next
      assign rem_in[k] = rem_r[k-1];
      assign lq_in[k]  = lq_r[k-1];
      assign dvs_in[k] = dvs_r[k-1];
    end

    always_comb begin
      rem_sh = {rem_in[k], lq_in[k][QW-1]};
      diff   = rem_sh - {1'b0, dvs_in[k]};
      ge     = (rem_sh >= {1'b0, dvs_in[k]});
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? diff[QW-1:0] : rem_sh[QW-1:0];
      lq_r[k]  <= {lq_in[k][QW-2:0], ge};
      dvs_r[k] <= dvs_in[k];
    end
  end

  assign quotient = lq_r[LAT-1];

endmodule
`default_nettype wire

// ===== rtl/saq_unitize.sv =====
`default_nettype none
module saq_unitize #(
  parameter int LANES     = 3,
  parameter int IN_W      = 32,
  parameter int FRAC_BITS = 30,
  parameter int SIDE_W    = 1
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_vld,
  input  logic [LANES-1:0][IN_W-1:0]              vec,
  input  logic [SIDE_W-1:0]                       side_in,
  output logic                                    out_vld,
  output logic [LANES-1:0][saq_pkg::UNIT_W-1:0]   unit_vec,
  output logic [SIDE_W-1:0]                       side_out
);

  localparam int NW       = saq_pkg::NORM_W;
  localparam int RW       = saq_pkg::RAD_W;
  localparam int QW       = saq_pkg::ROOT_W;
  localparam int UW       = saq_pkg::UNIT_W;
  localparam int BL_W     = $clog2(IN_W + 1);
  localparam int META_W   = 1 + LANES + SIDE_W;
  localparam int META_DLY = 3 + saq_pkg::SQRT_LAT + 1 + saq_pkg::DIV_LAT;
  localparam int NORM_DLY = 2 + saq_pkg::SQRT_LAT;

  logic [LANES-1:0][IN_W-1:0] mag_nxt, mag1_r, mag2_r;
  logic [LANES-1:0]           neg_nxt, neg1_r, neg2_r;
  logic [IN_W-1:0]            or_nxt, or1_r;
  logic [SIDE_W-1:0]          side1_r, side2_r;
  logic                       v1_r, v2_r;
  logic [BL_W-1:0]            blen_nxt, blen2_r;
  logic [BL_W-1:0]            lsh, rsh;
  logic [IN_W+NW-1:0]         ext, shl, shr;
  logic [LANES-1:0][NW-1:0]   norm_nxt, norm3_r, norm_d;
  logic [LANES-1:0][2*NW-1:0] sq4_r;
  logic [RW-1:0]              sum_nxt, sum5_r;
  logic [QW-1:0]              len_w;
  logic [LANES-1:0][RW-1:0]   dvd_r;
  logic [QW-1:0]              dvs_r;
  logic [LANES-1:0][QW-1:0]   quo_w;
  logic [META_W-1:0]          meta2, meta_d;
  logic                       zero_d;
  logic [LANES-1:0]           neg_d;
  logic [LANES-1:0][UW-1:0]   unit_r;
  logic [SIDE_W-1:0]          side_r;
  logic [META_DLY:0]          vpipe_r;

  // take magnitudes; the OR of all magnitudes has the bit length of the largest
  always_comb begin
    or_nxt = '0;
    for (int i = 0; i < LANES; i++) begin
      neg_nxt[i] = vec[i][IN_W-1];
      mag_nxt[i] = vec[i][IN_W-1] ? -vec[i] : vec[i];
      or_nxt     = or_nxt | mag_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    mag1_r  <= mag_nxt;
    neg1_r  <= neg_nxt;
    or1_r   <= or_nxt;
    side1_r <= side_in;
  end

  // find the bit length of the largest magnitude
  always_comb begin
    blen_nxt = '0;
    for (int i = 0; i < IN_W; i++) begin
      if (or1_r[i]) blen_nxt = BL_W'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    mag2_r  <= mag1_r;
    neg2_r  <= neg1_r;
    blen2_r <= blen_nxt;
    side2_r <= side1_r;
  end

  // shift so that the largest magnitude lands just below 2^31
  always_comb begin
    lsh = (blen2_r > BL_W'(NW)) ? '0 : BL_W'(NW) - blen2_r;
    rsh = (blen2_r > BL_W'(NW)) ? blen2_r - BL_W'(NW) : '0;
    ext = '0;
    shl = '0;
    shr = '0;
    for (int i = 0; i < LANES; i++) begin
      ext         = {{NW{1'b0}}, mag2_r[i]};
      shl         = ext << lsh;
      shr         = ext >> rsh;
      norm_nxt[i] = (blen2_r > BL_W'(NW)) ? shr[NW-1:0] : shl[NW-1:0];
    end
  end

  assign meta2 = {(blen2_r == '0), neg2_r, side2_r};

  always_ff @(posedge clk) begin
    norm3_r <= norm_nxt;
  end

  // square each component, then sum the squares
  always_ff @(posedge clk) begin
    for (int i = 0; i < LANES; i++) begin
      sq4_r[i] <= norm3_r[i] * norm3_r[i];
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < LANES; i++) begin
      sum_nxt = sum_nxt + RW'(sq4_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    sum5_r <= sum_nxt;
  end

  saq_isqrt u_isqrt (
    .clk  (clk),
    .rad  (sum5_r),
    .root (len_w)
  );

  saq_delay #(.W(LANES * NW), .DEPTH(NORM_DLY)) u_norm_dly (
    .clk  (clk),
    .din  (norm3_r),
    .dout (norm_d)
  );

  saq_delay #(.W(META_W), .DEPTH(META_DLY)) u_meta_dly (
    .clk  (clk),
    .din  (meta2),
    .dout (meta_d)
  );

  // form the rounded dividend m * 2^F + len/2 for each lane
  always_ff @(posedge clk) begin
    for (int i = 0; i < LANES; i++) begin
      dvd_r[i] <= (RW'(norm_d[i]) << FRAC_BITS) + RW'(len_w[QW-1:1]);
    end
    dvs_r <= len_w;
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    saq_div u_div (
      .clk      (clk),
      .dividend (dvd_r[i]),
      .divisor  (dvs_r),
      .quotient (quo_w[i])
    );
  end

  assign zero_d = meta_d[META_W-1];
  assign neg_d  = meta_d[SIDE_W +: LANES];

  // restore signs, force a zero vector to zero
  always_ff @(posedge clk) begin
    for (int i = 0; i < LANES; i++) begin
      if (zero_d) begin
        unit_r[i] <= '0;
      end else if (neg_d[i]) begin
        unit_r[i] <= -quo_w[i];
      end else begin
        unit_r[i] <= quo_w[i];
      end
    end
    side_r <= meta_d[SIDE_W-1:0];
  end

  // valid bits travel alongside the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      vpipe_r <= '0;
    end else begin
      v1_r    <= in_vld;
      v2_r    <= v1_r;
      vpipe_r <= {vpipe_r[META_DLY-1:0], v2_r};
    end
  end

  assign out_vld  = vpipe_r[META_DLY];
  assign unit_vec = unit_r;
  assign side_out = side_r;

endmodule
`default_nettype wire

// ===== rtl/shortest_arc_quaternion_core.sv =====
`default_nettype none
// Shortest-arc rotation quaternion core. Takes one start beat per clock and
// returns one result beat, marked by out_valid for a single cycle, for each
// start beat, in order; busy is always low and the receiver must take every
// result as it appears. Each item passes through two normalizers in series
// (source/destination, then the quaternion or generated axis), each holding
// a 32-step square-root pipeline followed by 32-step divider pipelines;
// every stage is fully pipelined, so throughput is one item per cycle.
module shortest_arc_quaternion_core #(
  parameter int FRAC_BITS = 30
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  saq_pkg::in_item_t   in_item,
  output logic                out_valid,
  output saq_pkg::out_item_t  out_item
);

  localparam int UW   = saq_pkg::UNIT_W;
  localparam int AX_W = 33;
  localparam int OUT_W = $bits(saq_pkg::out_item_t);
  localparam logic signed [31:0] ONE_F      = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] ONE_2F     = 64'sd1 <<< (2 * FRAC_BITS);
  localparam logic signed [63:0] OPP_MARGIN = ONE_2F / 64'sd1000000;
  localparam logic signed [63:0] OPP_LIMIT  = OPP_MARGIN - ONE_2F;

  function automatic logic signed [31:0] sat_unit(input logic signed [31:0] v);
    logic signed [31:0] r;
    r = v;
    if (v > ONE_F) begin
      r = ONE_F;
    end else if (v < -ONE_F) begin
      r = -ONE_F;
    end
    return r;
  endfunction

  logic                           accept;
  logic signed [AX_W-1:0]         sx, sy, sz;
  logic signed [AX_W-1:0]         ax_x, ax_y, ax_z;
  logic [2:0][31:0]               src_vec, dst_vec;
  logic [95:0]                    alt_in, alt_u;
  logic [3*AX_W-1:0]              ax_in, ax_u;
  logic [2:0][UW-1:0]             u0, u1;
  logic                           v0, v1;

  logic signed [63:0]             dp_r [0:2];
  logic signed [63:0]             pyz_r, pzy_r, pzx_r, pxz_r, pxy_r, pyx_r;
  logic [95:0]                    alt_m_r;
  logic [3*AX_W-1:0]              ax_m_r;
  logic                           vm_r;

  logic signed [63:0]             d_r, cx_r, cy_r, cz_r;
  logic [95:0]                    alt_a_r;
  logic [3*AX_W-1:0]              ax_a_r;
  logic                           va_r;

  logic signed [31:0]             alt_x, alt_y, alt_z;
  logic signed [AX_W-1:0]         gx, gy, gz;
  saq_pkg::out_item_t             fixed_item;
  logic [3:0][63:0]               vec2;
  logic                           v2;
  logic [OUT_W-1:0]               side2;
  logic [3:0][UW-1:0]             unit2;
  saq_pkg::out_item_t             side_f;
  saq_pkg::out_item_t             item_nxt;
  saq_pkg::out_item_t             out_item_r;
  logic                           out_valid_r;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // build the generated axis: X cross source, else Y cross source
  always_comb begin
    sx = AX_W'(in_item.src_x);
    sy = AX_W'(in_item.src_y);
    sz = AX_W'(in_item.src_z);
    if (in_item.src_y != 32'sd0 || in_item.src_z != 32'sd0) begin
      ax_x = '0;
      ax_y = -sz;
      ax_z = sy;
    end else begin
      ax_x = sz;
      ax_y = '0;
      ax_z = -sx;
    end
  end

  assign src_vec = {in_item.src_z, in_item.src_y, in_item.src_x};
  assign dst_vec = {in_item.dst_z, in_item.dst_y, in_item.dst_x};
  assign alt_in  = {in_item.alt_axis_x, in_item.alt_axis_y, in_item.alt_axis_z};
  assign ax_in   = {ax_x, ax_y, ax_z};

  saq_unitize #(.LANES(3), .IN_W(32), .FRAC_BITS(FRAC_BITS), .SIDE_W(96)) u_unit_src (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (accept),
    .vec      (src_vec),
    .side_in  (alt_in),
    .out_vld  (v0),
    .unit_vec (u0),
    .side_out (alt_u)
  );

  saq_unitize #(.LANES(3), .IN_W(32), .FRAC_BITS(FRAC_BITS), .SIDE_W(3 * AX_W)) u_unit_dst (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (accept),
    .vec      (dst_vec),
    .side_in  (ax_in),
    .out_vld  (v1),
    .unit_vec (u1),
    .side_out (ax_u)
  );

  // multiply terms of the dot and cross products
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dp_r[i] <= $signed(u0[i]) * $signed(u1[i]);
    end
    pyz_r   <= $signed(u0[1]) * $signed(u1[2]);
    pzy_r   <= $signed(u0[2]) * $signed(u1[1]);
    pzx_r   <= $signed(u0[2]) * $signed(u1[0]);
    pxz_r   <= $signed(u0[0]) * $signed(u1[2]);
    pxy_r   <= $signed(u0[0]) * $signed(u1[1]);
    pyx_r   <= $signed(u0[1]) * $signed(u1[0]);
    alt_m_r <= alt_u;
    ax_m_r  <= ax_u;
  end

  // sum the dot product and difference the cross terms
  always_ff @(posedge clk) begin
    d_r     <= dp_r[0] + dp_r[1] + dp_r[2];
    cx_r    <= pyz_r - pzy_r;
    cy_r    <= pzx_r - pxz_r;
    cz_r    <= pxy_r - pyx_r;
    alt_a_r <= alt_m_r;
    ax_a_r  <= ax_m_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
      va_r <= 1'b0;
    end else begin
      vm_r <= v0 & v1;
      va_r <= vm_r;
    end
  end

  // choose the path and what the second normalizer works on
  always_comb begin
    alt_x = alt_a_r[95:64];
    alt_y = alt_a_r[63:32];
    alt_z = alt_a_r[31:0];
    gx    = ax_a_r[3*AX_W-1 -: AX_W];
    gy    = ax_a_r[2*AX_W-1 -: AX_W];
    gz    = ax_a_r[AX_W-1:0];
    fixed_item = '0;
    vec2 = {cz_r, cy_r, cx_r, ONE_2F + d_r};
    if (d_r >= ONE_2F) begin
      fixed_item.quat_w     = ONE_F;
      fixed_item.path_taken = saq_pkg::PATH_IDENT;
    end else if (d_r < OPP_LIMIT) begin
      if (alt_x != 32'sd0 || alt_y != 32'sd0 || alt_z != 32'sd0) begin
        fixed_item.quat_x     = sat_unit(alt_x);
        fixed_item.quat_y     = sat_unit(alt_y);
        fixed_item.quat_z     = sat_unit(alt_z);
        fixed_item.path_taken = saq_pkg::PATH_ALT;
      end else begin
        fixed_item.path_taken = saq_pkg::PATH_GEN;
        vec2 = {64'(gz), 64'(gy), 64'(gx), 64'sd0};
      end
    end else begin
      fixed_item.path_taken = saq_pkg::PATH_GENERAL;
    end
  end

  saq_unitize #(.LANES(4), .IN_W(64), .FRAC_BITS(FRAC_BITS), .SIDE_W(OUT_W)) u_unit_quat (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (va_r),
    .vec      (vec2),
    .side_in  (fixed_item),
    .out_vld  (v2),
    .unit_vec (unit2),
    .side_out (side2)
  );

  // merge normalized results with the fixed-result paths
  always_comb begin
    side_f   = saq_pkg::out_item_t'(side2);
    item_nxt = side_f;
    if (side_f.path_taken == saq_pkg::PATH_GEN ||
        side_f.path_taken == saq_pkg::PATH_GENERAL) begin
      item_nxt.quat_w = sat_unit($signed(unit2[0]));
      item_nxt.quat_x = sat_unit($signed(unit2[1]));
      item_nxt.quat_y = sat_unit($signed(unit2[2]));
      item_nxt.quat_z = sat_unit($signed(unit2[3]));
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v2;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire
